// ===== src/assert_macros.svh =====
// assertion macros shared by the accumulator rtl
// no dependencies; expects clk and arst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define PRAA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define PRAA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/praa_pkg.sv =====
// shared types, codes and constants of the pixel running average accumulator
// no dependencies
package praa_pkg;

	localparam int DEF_IMAGE_WIDTH  = 256;
	localparam int DEF_IMAGE_HEIGHT = 256;

	localparam int MEAN_W  = 24;
	localparam int CNT_W   = 16;
	localparam int NUM_W   = MEAN_W + CNT_W + 1;
	localparam int DEN_W   = CNT_W + 1;
	localparam int STEP_W  = 5;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// operation codes carried in tuser
	localparam logic [1:0] OP_ACC  = 2'd0;
	localparam logic [1:0] OP_RD   = 2'd1;
	localparam logic [1:0] OP_CLR  = 2'd2;
	// spare code, handled as a read
	localparam logic [1:0] OP_RSVD = 2'd3;

	// one stored pixel, red in the top bits
	typedef struct packed {
		logic [MEAN_W-1:0] red;
		logic [MEAN_W-1:0] green;
		logic [MEAN_W-1:0] blue;
		logic [MEAN_W-1:0] alpha;
		logic [CNT_W-1:0]  cnt;
	} pix_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_start;
		logic clr_step;
		logic rd;
		logic mul;
		logic div_start;
		logic wr;
		logic res_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;
		logic is_acc;
		logic clr_last;
		logic div_done;
	} sts_t;

endpackage

// ===== src/pixel_running_average_accumulator.sv =====
// top level of the per-pixel running average accumulator
// depends on praa_pkg, praa_ctrl, praa_dp (and praa_div below it)
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata 96 bits, s_tuser 2 bits (op)
//  m_       out  m_tvalid/m_tready  m_tdata 112 bits
//
// accumulate: store read, products, the quotient steps of the divider lanes, store write
// read: through the store read port; an out-of-range item skips the store
// clear: a sweep over all IMAGE_WIDTH*IMAGE_HEIGHT entries, one store entry per cycle
// after reset a sweep over all IMAGE_WIDTH*IMAGE_HEIGHT entries clears the store
// a held result stalls only the next finish; a new item is taken meanwhile
module pixel_running_average_accumulator #(
	parameter int IMAGE_WIDTH  = praa_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = praa_pkg::DEF_IMAGE_HEIGHT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pixel_x, pixel_y, exposure, red_weight, green_weight, blue_weight, alpha_in
	input  logic [95:0]  s_tdata,
	// op
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// red_mean, green_mean, blue_mean, alpha_mean, sample_total
	output logic [111:0] m_tdata
);
	import praa_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [MEAN_W-1:0] red_mean, green_mean, blue_mean, alpha_mean;
	logic [CNT_W-1:0]  sample_total;

	praa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.op      (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	praa_dp #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (s_tuser),
		.pixel_x     (s_tdata[7:0]),
		.pixel_y     (s_tdata[15:8]),
		.exposure    (s_tdata[31:16]),
		.red_weight  (s_tdata[47:32]),
		.green_weight(s_tdata[63:48]),
		.blue_weight (s_tdata[79:64]),
		.alpha_in    (s_tdata[95:80]),
		.cmd         (cmd),
		.sts         (sts),
		.red_mean    (red_mean),
		.green_mean  (green_mean),
		.blue_mean   (blue_mean),
		.alpha_mean  (alpha_mean),
		.sample_total(sample_total)
	);

	// result packing, red in the lowest bits
	assign m_tdata = {sample_total, alpha_mean, blue_mean, green_mean, red_mean};

endmodule

// ===== src/praa_div.sv =====
// radix-2 restoring divider lane, one quotient bit per cycle
// depends on praa_pkg; quotient must fit in MEAN_W bits
module praa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [praa_pkg::NUM_W-1:0] num,
	input  logic [praa_pkg::DEN_W-1:0] den,
	output logic [praa_pkg::MEAN_W-1:0] quo,
	output logic                       done
);
	import praa_pkg::*;

	logic [DEN_W-1:0]  rem_q;
	logic [MEAN_W-1:0] quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DEN_W:0]    trial;
	logic              ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[MEAN_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (done)
				busy_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:MEAN_W];
			quo_q <= num[MEAN_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[MEAN_W-2:0], ge};
		end
	end

	assign done = busy_q && (step_q == STEP_W'(MEAN_W - 1));
	assign quo  = quo_q;

endmodule

// ===== src/praa_dp.sv =====
// datapath: pixel store, sample products, four divider lanes, result register
// depends on praa_pkg and praa_div
module praa_dp #(
	parameter int IMAGE_WIDTH  = praa_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = praa_pkg::DEF_IMAGE_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   op,
	input  logic [7:0]                   pixel_x,
	input  logic [7:0]                   pixel_y,
	input  logic signed [15:0]           exposure,
	input  logic [15:0]                  red_weight,
	input  logic [15:0]                  green_weight,
	input  logic [15:0]                  blue_weight,
	input  logic [15:0]                  alpha_in,
	input  praa_pkg::cmd_t               cmd,
	output praa_pkg::sts_t               sts,
	output logic [praa_pkg::MEAN_W-1:0]  red_mean,
	output logic [praa_pkg::MEAN_W-1:0]  green_mean,
	output logic [praa_pkg::MEAN_W-1:0]  blue_mean,
	output logic [praa_pkg::MEAN_W-1:0]  alpha_mean,
	output logic [praa_pkg::CNT_W-1:0]   sample_total
);
	import praa_pkg::*;

	localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	pix_t mem [PIXELS];

	logic [1:0]        op_q;
	logic              bad_q;
	logic [AW-1:0]     addr_q;
	logic [14:0]       expo_q;
	logic [15:0]       wr_q, wg_q, wb_q, al_q;
	logic [AW-1:0]     clr_q;
	pix_t              rdata_q;
	logic [31:0]       idx_full;
	logic              bad_in;

	logic [MEAN_W+CNT_W-1:0] prod_s2 [4];
	logic [30:0]             cprod_s2 [3];
	logic [15:0]             alpha_s2;
	logic [NUM_W-1:0]        num [4];
	logic [MEAN_W-1:0]       quo [4];
	logic [3:0]              done;
	logic [38:0]             c255 [3];
	logic [23:0]             a255;
	logic [DEN_W-1:0]        den;
	logic [CNT_W-1:0]        k_new;
	pix_t                    wdata;
	pix_t                    res;

	// pixel index and range check
	always_comb begin
		idx_full = 32'(pixel_y) * 32'(IMAGE_WIDTH) + 32'(pixel_x);
		bad_in   = (32'(pixel_x) >= 32'(IMAGE_WIDTH)) || (32'(pixel_y) >= 32'(IMAGE_HEIGHT));
	end

	// capture of the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			bad_q  <= bad_in;
			addr_q <= idx_full[AW-1:0];
			expo_q <= exposure[15] ? 15'd0 : exposure[14:0];
			wr_q   <= red_weight;
			wg_q   <= green_weight;
			wb_q   <= blue_weight;
			al_q   <= alpha_in;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_start)
			clr_q <= '0;
		else if (cmd.clr_step)
			clr_q <= clr_q + 1'b1;
	end

	// pixel store, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			mem[clr_q] <= '0;
		else if (cmd.wr)
			mem[addr_q] <= wdata;
		if (cmd.rd)
			rdata_q <= mem[addr_q];
	end

	// products: stored mean times count, exposure times weight
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s2[0]  <= 40'(rdata_q.red)   * 40'(rdata_q.cnt);
			prod_s2[1]  <= 40'(rdata_q.green) * 40'(rdata_q.cnt);
			prod_s2[2]  <= 40'(rdata_q.blue)  * 40'(rdata_q.cnt);
			prod_s2[3]  <= 40'(rdata_q.alpha) * 40'(rdata_q.cnt);
			cprod_s2[0] <= 31'(expo_q) * 31'(wr_q);
			cprod_s2[1] <= 31'(expo_q) * 31'(wg_q);
			cprod_s2[2] <= 31'(expo_q) * 31'(wb_q);
			alpha_s2    <= al_q;
		end
	end

	// samples scaled by 255 and dividends
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c255[i] = {cprod_s2[i], 8'd0} - {8'd0, cprod_s2[i]};
			num[i]  = NUM_W'(prod_s2[i]) + NUM_W'(c255[i][38:20]);
		end
		a255   = {alpha_s2, 8'd0} - {8'd0, alpha_s2};
		num[3] = NUM_W'(prod_s2[3]) + NUM_W'(a255[23:8]);
		den    = {1'b0, rdata_q.cnt} + 1'b1;
	end

	// divider lanes, one per channel
	for (genvar g = 0; g < 4; g++) begin : g_lane
		praa_div u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.start (cmd.div_start),
			.num   (num[g]),
			.den   (den),
			.quo   (quo[g]),
			.done  (done[g])
		);
	end

	// updated pixel
	always_comb begin
		k_new       = (rdata_q.cnt == COUNT_MAX) ? rdata_q.cnt : rdata_q.cnt + 1'b1;
		wdata.red   = quo[0];
		wdata.green = quo[1];
		wdata.blue  = quo[2];
		wdata.alpha = quo[3];
		wdata.cnt   = k_new;
	end

	// result selection
	always_comb begin
		priority if (bad_q || op_q == OP_CLR)
			res = '0;
		else if (op_q == OP_ACC)
			res = wdata;
		else
			res = rdata_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			red_mean     <= res.red;
			green_mean   <= res.green;
			blue_mean    <= res.blue;
			alpha_mean   <= res.alpha;
			sample_total <= res.cnt;
		end
	end

	assign sts.bad      = bad_q;
	assign sts.is_acc   = (op_q == OP_ACC);
	assign sts.clr_last = (clr_q == AW'(PIXELS - 1));
	assign sts.div_done = done[0];

endmodule

// ===== src/praa_ctrl.sv =====
// controller state machine: sequencing of capture, sweep, read, divide, write
// depends on praa_pkg and assert_macros.svh
module praa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [1:0]     op,
	output logic           m_tvalid,
	input  logic           m_tready,
	output praa_pkg::cmd_t cmd,
	input  praa_pkg::sts_t sts
);
	import praa_pkg::*;
	`include "assert_macros.svh"

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_RDW  = 4'd3;
	localparam logic [3:0] ST_SUM  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_WR   = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;

	logic [3:0] st_q, st_d;
	logic       pend_q, pend_d;
	logic       mvalid_q;

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = mvalid_q;

	// next state and commands
	always_comb begin
		st_d   = st_q;
		pend_d = pend_q;
		cmd    = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					if (op == OP_CLR) begin
						cmd.clr_start = 1'b1;
						pend_d        = 1'b1;
						st_d          = ST_CLR;
					end else begin
						st_d = ST_RD;
					end
				end
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					st_d = pend_q ? ST_FIN : ST_IDLE;
			end
			ST_RD: begin
				if (sts.bad) begin
					st_d = ST_FIN;
				end else begin
					cmd.rd = 1'b1;
					st_d   = ST_RDW;
				end
			end
			ST_RDW: begin
				if (sts.is_acc) begin
					cmd.mul = 1'b1;
					st_d    = ST_SUM;
				end else begin
					st_d = ST_FIN;
				end
			end
			ST_SUM: begin
				cmd.div_start = 1'b1;
				st_d          = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done)
					st_d = ST_WR;
			end
			ST_WR: begin
				cmd.wr = 1'b1;
				st_d   = ST_FIN;
			end
			ST_FIN: begin
				if (!mvalid_q || m_tready) begin
					cmd.res_load = 1'b1;
					pend_d       = 1'b0;
					st_d         = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// state, clear pending flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLR;
			pend_q   <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			pend_q <= pend_d;
			if (cmd.res_load)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
		end
	end

	`PRAA_ASSERT(a_no_accept_in_sweep, (st_q == ST_CLR) |-> !s_tready, "item taken during sweep")
	`PRAA_ASSERT(a_leave_idle, (s_tvalid && s_tready) |=> (st_q != ST_IDLE), "idle after transfer")
	`PRAA_ASSERT_ALWAYS(a_no_port_clash, !(cmd.wr && cmd.clr_step), "store write clash")

endmodule
